>>> sv/lspp_pkg.sv
package lspp_pkg;

  localparam int unsigned PIX_W   = 16;
  localparam int unsigned DIF_W   = PIX_W + 1;
  localparam int unsigned NCH     = 3;
  localparam int unsigned SQR_W   = 2 * PIX_W;
  localparam int unsigned SQ_W    = 34;
  localparam int unsigned MAG_W   = 17;
  localparam int unsigned ISCL_W  = 24;
  localparam int unsigned SUM_W   = 19;
  localparam int unsigned PROD_W  = SUM_W + ISCL_W;
  localparam int unsigned DEN_W   = 17;
  localparam int unsigned DV_W    = DEN_W + MAG_W;
  localparam int unsigned P1_W    = 2 * PIX_W;
  localparam int unsigned NA_W    = P1_W + PIX_W;
  localparam int unsigned NUM_W   = NA_W + 1;
  localparam int unsigned Q_W     = 17;
  localparam int unsigned FRAC_SH = 32;

  localparam int unsigned PADDR_W = 5;
  localparam int unsigned PDATA_W = 32;

  localparam logic [ISCL_W-1:0] INV_SCALE_RST = 24'd98866;
  localparam logic [PIX_W-1:0]  GAIN_RST      = 16'd6128;
  localparam logic [PIX_W-1:0]  EXP_DELTA_RST = 16'd65535;
  localparam logic [PIX_W-1:0]  ERF_FULL      = 16'd65535;

  typedef enum logic [2:0] {
    REG_SINGLE    = 3'd0,
    REG_DELTA     = 3'd1,
    REG_INV_SCALE = 3'd2,
    REG_GAIN      = 3'd3,
    REG_EXP_DELTA = 3'd4,
    REG_ERF_DELTA = 3'd5
  } reg_idx_e;

  typedef struct packed {
    logic              single;
    logic [PIX_W-1:0]  delta_offset;
    logic [ISCL_W-1:0] inv_scale;
    logic [PIX_W-1:0]  gain;
    logic [PIX_W-1:0]  exp_delta;
    logic [PIX_W-1:0]  erf_delta;
  } cfg_t;

  typedef struct packed {
    logic [PIX_W-1:0] src;
    logic             neg;
    logic             skip;
  } lane_side_t;

endpackage

>>> sv/lspp_regs.sv
module lspp_regs (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [lspp_pkg::PADDR_W-1:0]   paddr,
  input  logic [lspp_pkg::PDATA_W-1:0]   pwdata,
  output logic [lspp_pkg::PDATA_W-1:0]   prdata,
  output logic                           pready,
  output lspp_pkg::cfg_t                 cfg_o
);
  import lspp_pkg::*;

  cfg_t     cfg_q;
  reg_idx_e idx;
  logic     wr;

  assign idx    = reg_idx_e'(paddr[PADDR_W-1:2]);
  assign wr     = psel & penable & pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.single       <= 1'b0;
      cfg_q.delta_offset <= '0;
      cfg_q.inv_scale    <= INV_SCALE_RST;
      cfg_q.gain         <= GAIN_RST;
      cfg_q.exp_delta    <= EXP_DELTA_RST;
      cfg_q.erf_delta    <= '0;
    end else if (wr) begin
      case (idx)
        REG_SINGLE:    cfg_q.single       <= pwdata[0];
        REG_DELTA:     cfg_q.delta_offset <= pwdata[PIX_W-1:0];
        REG_INV_SCALE: cfg_q.inv_scale    <= pwdata[ISCL_W-1:0];
        REG_GAIN:      cfg_q.gain         <= pwdata[PIX_W-1:0];
        REG_EXP_DELTA: cfg_q.exp_delta    <= pwdata[PIX_W-1:0];
        REG_ERF_DELTA: cfg_q.erf_delta    <= pwdata[PIX_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_SINGLE:    prdata = PDATA_W'(cfg_q.single);
      REG_DELTA:     prdata = PDATA_W'(cfg_q.delta_offset);
      REG_INV_SCALE: prdata = PDATA_W'(cfg_q.inv_scale);
      REG_GAIN:      prdata = PDATA_W'(cfg_q.gain);
      REG_EXP_DELTA: prdata = PDATA_W'(cfg_q.exp_delta);
      REG_ERF_DELTA: prdata = PDATA_W'(cfg_q.erf_delta);
      default:       prdata = '0;
    endcase
  end

endmodule

>>> sv/lspp_sqrt.sv
module lspp_sqrt #(
  parameter int unsigned PW = 1
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         en_i,
  input  logic                         valid_i,
  input  logic [lspp_pkg::SQ_W-1:0]    rad_i,
  input  logic [PW-1:0]                side_i,
  output logic                         valid_o,
  output logic [lspp_pkg::MAG_W-1:0]   root_o,
  output logic [PW-1:0]                side_o
);
  import lspp_pkg::*;

  localparam int unsigned TW = SQ_W + 1;

  logic             v_q    [MAG_W];
  logic [SQ_W-1:0]  rem_q  [MAG_W];
  logic [MAG_W-1:0] root_q [MAG_W];
  logic [PW-1:0]    side_q [MAG_W];

  // one root bit per stage, remainder kept as rad - root^2
  for (genvar k = 0; k < MAG_W; k++) begin : g_stg
    localparam int unsigned B = MAG_W - 1 - k;
    logic             cv;
    logic [SQ_W-1:0]  crem;
    logic [MAG_W-1:0] croot;
    logic [PW-1:0]    cside;
    logic [TW-1:0]    trial;
    logic             ge;

    if (k == 0) begin : g_first
      assign cv    = valid_i;
      assign crem  = rad_i;
      assign croot = '0;
      assign cside = side_i;
    end else begin : g_next
      assign cv    = v_q[k-1];
      assign crem  = rem_q[k-1];
      assign croot = root_q[k-1];
      assign cside = side_q[k-1];
    end

    assign trial = (TW'(croot) << (B + 1)) | (TW'(1) << (2 * B));
    assign ge    = TW'(crem) >= trial;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else if (en_i) begin
        v_q[k] <= cv;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k]  <= ge ? SQ_W'(TW'(crem) - trial) : crem;
        root_q[k] <= ge ? (croot | (MAG_W'(1) << B)) : croot;
        side_q[k] <= cside;
      end
    end
  end

  assign valid_o = v_q[MAG_W-1];
  assign root_o  = root_q[MAG_W-1];
  assign side_o  = side_q[MAG_W-1];

endmodule

>>> sv/lspp_div.sv
module lspp_div #(
  parameter int unsigned PW = 1
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        en_i,
  input  logic                        valid_i,
  input  logic [lspp_pkg::NUM_W-1:0]  num_i,
  input  logic [lspp_pkg::DV_W-1:0]   den_i,
  input  logic [PW-1:0]               side_i,
  output logic                        valid_o,
  output logic [lspp_pkg::Q_W-1:0]    quo_o,
  output logic                        ovf_o,
  output logic [PW-1:0]               side_o
);
  import lspp_pkg::*;

  localparam int unsigned CW = DV_W + Q_W;

  logic             v0_q;
  logic [NUM_W-1:0] rem0_q;
  logic [DV_W-1:0]  den0_q;
  logic             ovf0_q;
  logic [PW-1:0]    side0_q;

  logic             v_q    [Q_W];
  logic [NUM_W-1:0] rem_q  [Q_W];
  logic [DV_W-1:0]  den_q  [Q_W];
  logic [Q_W-1:0]   quo_q  [Q_W];
  logic             ovf_q  [Q_W];
  logic [PW-1:0]    side_q [Q_W];

  // quotient too large for the bit stages: caller saturates
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
    end else if (en_i) begin
      v0_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem0_q  <= num_i;
      den0_q  <= den_i;
      ovf0_q  <= CW'(num_i) >= (CW'(den_i) << Q_W);
      side0_q <= side_i;
    end
  end

  for (genvar k = 0; k < Q_W; k++) begin : g_stg
    localparam int unsigned B = Q_W - 1 - k;
    logic             cv;
    logic [NUM_W-1:0] crem;
    logic [DV_W-1:0]  cden;
    logic [Q_W-1:0]   cquo;
    logic             covf;
    logic [PW-1:0]    cside;
    logic [CW-1:0]    sub;
    logic             ge;

    if (k == 0) begin : g_first
      assign cv    = v0_q;
      assign crem  = rem0_q;
      assign cden  = den0_q;
      assign cquo  = '0;
      assign covf  = ovf0_q;
      assign cside = side0_q;
    end else begin : g_next
      assign cv    = v_q[k-1];
      assign crem  = rem_q[k-1];
      assign cden  = den_q[k-1];
      assign cquo  = quo_q[k-1];
      assign covf  = ovf_q[k-1];
      assign cside = side_q[k-1];
    end

    assign sub = CW'(cden) << B;
    assign ge  = CW'(crem) >= sub;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else if (en_i) begin
        v_q[k] <= cv;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k]  <= ge ? NUM_W'(CW'(crem) - sub) : crem;
        den_q[k]  <= cden;
        quo_q[k]  <= ge ? (cquo | (Q_W'(1) << B)) : cquo;
        ovf_q[k]  <= covf;
        side_q[k] <= cside;
      end
    end
  end

  assign valid_o = v_q[Q_W-1];
  assign quo_o   = quo_q[Q_W-1];
  assign ovf_o   = ovf_q[Q_W-1];
  assign side_o  = side_q[Q_W-1];

endmodule

>>> sv/lspp_rom.sv
module lspp_rom #(
  parameter int unsigned DEPTH = 1024
) (
  input  logic                        clk_i,
  input  logic                        en_i,
  input  logic [$clog2(DEPTH)-1:0]    idx_i,
  output logic [lspp_pkg::PIX_W-1:0]  exp_o,
  output logic [lspp_pkg::PIX_W-1:0]  erf_o
);
  import lspp_pkg::*;

  localparam logic [63:0] OneQ32    = 64'd1 << 32;
  localparam logic [63:0] TwoRsqrtPi = 64'd2423175810;

  function automatic logic [63:0] mul_q32(input logic [63:0] a, input logic [63:0] b);
    logic [63:0] p;
    p = a * b + 64'h8000_0000;
    return p >> 32;
  endfunction

  function automatic logic [PIX_W-1:0] to_q16(input logic [63:0] x);
    logic [63:0] v;
    v = (x + 64'd32768) >> 16;
    return (v > 64'd65535) ? 16'hFFFF : v[PIX_W-1:0];
  endfunction

  // step ratio exp(-h^2) for h = 4/DEPTH, cubic taylor term in q0.32
  localparam logic [63:0] DepthSq   = 64'(DEPTH) * 64'(DEPTH);
  localparam logic [63:0] HStepSq   = ((64'd16 << 32) + DepthSq / 64'd2) / DepthSq;
  localparam logic [63:0] Taylor2   = ((HStepSq * HStepSq) >> 32) / 64'd2;
  localparam logic [63:0] Taylor3   = ((Taylor2 * HStepSq) >> 32) / 64'd3;
  localparam logic [63:0] Ratio     = OneQ32 - HStepSq + Taylor2 - Taylor3;
  localparam logic [63:0] RatioSq   = mul_q32(Ratio, Ratio);
  localparam logic [63:0] HalfDepth = 64'(DEPTH) / 64'd2;

  // exp(-x^2) by a geometric recurrence, erf by trapezoid sums of it
  function automatic logic [DEPTH-1:0][2*PIX_W-1:0] build_rom();
    logic [DEPTH-1:0][2*PIX_W-1:0] t;
    logic [63:0] e, q, acc, e_new, integ, ev;
    e   = OneQ32;
    q   = Ratio;
    acc = '0;
    t[0] = {to_q16(e), 16'd0};
    for (int k = 1; k < DEPTH; k++) begin
      e_new = mul_q32(e, q);
      acc   = acc + e + e_new;
      integ = (acc * 64'd2 + HalfDepth) / 64'(DEPTH);
      ev    = (integ * TwoRsqrtPi + 64'h4000_0000) >> 31;
      t[k]  = {to_q16(e_new), to_q16(ev)};
      e     = e_new;
      q     = mul_q32(q, RatioSq);
    end
    return t;
  endfunction

  localparam logic [DEPTH-1:0][2*PIX_W-1:0] Rom = build_rom();

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      {exp_o, erf_o} <= Rom[idx_i];
    end
  end

endmodule

>>> sv/local_statistics_prior_pixel_core.sv
// channel  | signals                                   | role
// ---------+-------------------------------------------+-------------------------
// pixel in | in_valid_i/in_ready_o, src_ch*, smooth_ch* | one word per pixel
// pixel out| out_valid_o/out_ready_i, out_ch*_o          | one filtered word
// config   | psel penable pwrite paddr pwdata prdata    | apb registers at 4*i
//
// one word per cycle sustained while the output is not stalled; the pipe is built from the 17-stage
// square root and the 18-stage divider lanes plus the arithmetic stages
// a stall on out_ready_i freezes every stage; in_ready_o is low only then
// reset clears all stage valid bits and loads the register defaults
module local_statistics_prior_pixel_core #(
  parameter int unsigned FUNC_TABLE_DEPTH = 1024
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [lspp_pkg::PIX_W-1:0]   src_ch0_i,
  input  logic [lspp_pkg::PIX_W-1:0]   src_ch1_i,
  input  logic [lspp_pkg::PIX_W-1:0]   src_ch2_i,
  input  logic [lspp_pkg::PIX_W-1:0]   smooth_ch0_i,
  input  logic [lspp_pkg::PIX_W-1:0]   smooth_ch1_i,
  input  logic [lspp_pkg::PIX_W-1:0]   smooth_ch2_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [lspp_pkg::PIX_W-1:0]   out_ch0_o,
  output logic [lspp_pkg::PIX_W-1:0]   out_ch1_o,
  output logic [lspp_pkg::PIX_W-1:0]   out_ch2_o,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [lspp_pkg::PADDR_W-1:0] paddr,
  input  logic [lspp_pkg::PDATA_W-1:0] pwdata,
  output logic [lspp_pkg::PDATA_W-1:0] prdata,
  output logic                         pready
);
  import lspp_pkg::*;

  localparam int unsigned IDX_W = $clog2(FUNC_TABLE_DEPTH);
  localparam int unsigned SCL_W = PROD_W + IDX_W + 1;
  localparam int unsigned IDF_W = SCL_W - FRAC_SH;
  localparam int unsigned LSW   = $bits(lane_side_t);
  localparam int unsigned OW    = Q_W + 2;

  typedef struct packed {
    logic [NCH-1:0][PIX_W-1:0] src;
    logic [NCH-1:0][PIX_W-1:0] absd;
    logic [NCH-1:0]            dneg;
  } pix_t;

  cfg_t cfg;
  logic en;

  lspp_regs u_regs (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .cfg_o (cfg)
  );

  logic out_valid_q;
  logic [NCH-1:0][PIX_W-1:0] out_q;

  assign en         = !out_valid_q || out_ready_i;
  assign in_ready_o = en;

  // input register
  logic a_v_q;
  logic [NCH-1:0][PIX_W-1:0] a_src_q, a_sm_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) a_v_q <= 1'b0;
    else if (en) a_v_q <= in_valid_i;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      a_src_q <= {src_ch2_i, src_ch1_i, src_ch0_i};
      a_sm_q  <= {smooth_ch2_i, smooth_ch1_i, smooth_ch0_i};
    end
  end

  // differences
  logic b_v_q;
  pix_t b_pix_q, b_pix_d;

  always_comb begin
    logic [DIF_W-1:0] dif;
    b_pix_d.src = a_src_q;
    for (int j = 0; j < NCH; j++) begin
      dif = {1'b0, a_src_q[j]} - {1'b0, a_sm_q[j]};
      b_pix_d.dneg[j] = dif[DIF_W-1];
      b_pix_d.absd[j] = dif[DIF_W-1] ? PIX_W'(-dif) : dif[PIX_W-1:0];
      if (cfg.single && j != 0) begin
        b_pix_d.absd[j] = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) b_v_q <= 1'b0;
    else if (en) b_v_q <= a_v_q;
  end

  always_ff @(posedge clk_i) begin
    if (en) b_pix_q <= b_pix_d;
  end

  // squares
  logic c_v_q;
  pix_t c_pix_q;
  logic [NCH-1:0][SQR_W-1:0] c_sq_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) c_v_q <= 1'b0;
    else if (en) c_v_q <= b_v_q;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      c_pix_q <= b_pix_q;
      for (int j = 0; j < NCH; j++) begin
        c_sq_q[j] <= SQR_W'(b_pix_q.absd[j]) * SQR_W'(b_pix_q.absd[j]);
      end
    end
  end

  // sum of squares
  logic d_v_q;
  pix_t d_pix_q;
  logic [SQ_W-1:0] d_sum_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) d_v_q <= 1'b0;
    else if (en) d_v_q <= c_v_q;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      d_pix_q <= c_pix_q;
      d_sum_q <= SQ_W'(c_sq_q[0]) + SQ_W'(c_sq_q[1]) + SQ_W'(c_sq_q[2]);
    end
  end

  logic             s_v;
  logic [MAG_W-1:0] s_mag;
  pix_t             s_pix;

  lspp_sqrt #(.PW($bits(pix_t))) u_sqrt (
    .clk_i, .rst_ni, .en_i(en), .valid_i(d_v_q), .rad_i(d_sum_q), .side_i(d_pix_q),
    .valid_o(s_v), .root_o(s_mag), .side_o(s_pix)
  );

  // eps product
  logic e_v_q;
  pix_t e_pix_q;
  logic [MAG_W-1:0]  e_mag_q;
  logic [PROD_W-1:0] e_prod_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) e_v_q <= 1'b0;
    else if (en) e_v_q <= s_v;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      e_pix_q  <= s_pix;
      e_mag_q  <= s_mag;
      e_prod_q <= PROD_W'(SUM_W'(cfg.delta_offset) + (SUM_W'(s_mag) << 1))
                * PROD_W'(cfg.inv_scale);
    end
  end

  // table index
  logic f_v_q, f_in_q;
  pix_t f_pix_q;
  logic [MAG_W-1:0] f_mag_q;
  logic [IDX_W-1:0] f_idx_q;
  logic [SCL_W-1:0] scaled;
  logic [IDF_W-1:0] idx_full;

  assign scaled   = SCL_W'(e_prod_q) * SCL_W'(FUNC_TABLE_DEPTH) + (SCL_W'(1) << (FRAC_SH - 1));
  assign idx_full = scaled[SCL_W-1:FRAC_SH];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) f_v_q <= 1'b0;
    else if (en) f_v_q <= e_v_q;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      f_pix_q <= e_pix_q;
      f_mag_q <= e_mag_q;
      f_in_q  <= idx_full < IDF_W'(FUNC_TABLE_DEPTH);
      f_idx_q <= idx_full[IDX_W-1:0];
    end
  end

  // table read
  logic g_v_q, g_in_q;
  pix_t g_pix_q;
  logic [MAG_W-1:0] g_mag_q;
  logic [PIX_W-1:0] rom_exp, rom_erf;

  lspp_rom #(.DEPTH(FUNC_TABLE_DEPTH)) u_rom (
    .clk_i, .en_i(en), .idx_i(f_idx_q), .exp_o(rom_exp), .erf_o(rom_erf)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) g_v_q <= 1'b0;
    else if (en) g_v_q <= f_v_q;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      g_pix_q <= f_pix_q;
      g_mag_q <= f_mag_q;
      g_in_q  <= f_in_q;
    end
  end

  // numerator and denominator terms
  logic h_v_q, h_nneg_q;
  pix_t h_pix_q;
  logic [MAG_W-1:0] h_mag_q;
  logic [PIX_W-1:0] h_nabs_q;
  logic [DEN_W-1:0] h_den_q;
  logic [PIX_W-1:0] ex, er;
  logic [DIF_W-1:0] num;

  // past the table end: exp reads zero, erf reads full scale
  assign ex  = g_in_q ? rom_exp : '0;
  assign er  = g_in_q ? rom_erf : ERF_FULL;
  assign num = {1'b0, ex} - {1'b0, cfg.exp_delta};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) h_v_q <= 1'b0;
    else if (en) h_v_q <= g_v_q;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      h_pix_q  <= g_pix_q;
      h_mag_q  <= g_mag_q;
      h_nneg_q <= num[DIF_W-1];
      h_nabs_q <= num[DIF_W-1] ? PIX_W'(-num) : num[PIX_W-1:0];
      h_den_q  <= DEN_W'(er) + DEN_W'(cfg.erf_delta);
    end
  end

  // gain product and divisor
  logic i_v_q, i_nneg_q, i_skip_q;
  pix_t i_pix_q;
  logic [P1_W-1:0] i_p1_q;
  logic [DV_W-1:0] i_dv_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) i_v_q <= 1'b0;
    else if (en) i_v_q <= h_v_q;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      i_pix_q  <= h_pix_q;
      i_nneg_q <= h_nneg_q;
      i_p1_q   <= P1_W'(h_nabs_q) * P1_W'(cfg.gain);
      i_dv_q   <= DV_W'(h_den_q) * DV_W'(h_mag_q);
      i_skip_q <= (h_mag_q == '0) || (h_den_q == '0);
    end
  end

  // per-channel numerators
  logic j_v_q, j_skip_q;
  logic [NCH-1:0] j_neg_q;
  logic [NCH-1:0][PIX_W-1:0] j_src_q;
  logic [NCH-1:0][NA_W-1:0]  j_na_q;
  logic [DV_W-1:0] j_dv_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) j_v_q <= 1'b0;
    else if (en) j_v_q <= i_v_q;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      j_src_q  <= i_pix_q.src;
      j_dv_q   <= i_dv_q;
      j_skip_q <= i_skip_q;
      for (int j = 0; j < NCH; j++) begin
        j_na_q[j]  <= NA_W'(i_p1_q) * NA_W'(i_pix_q.absd[j]);
        j_neg_q[j] <= i_nneg_q ^ i_pix_q.dneg[j];
      end
    end
  end

  // rounding bias
  logic k_v_q;
  logic [NCH-1:0][NUM_W-1:0] k_num_q;
  logic [DV_W-1:0] k_dv_q;
  lane_side_t [NCH-1:0] k_side_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) k_v_q <= 1'b0;
    else if (en) k_v_q <= j_v_q;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      k_dv_q <= j_dv_q;
      for (int j = 0; j < NCH; j++) begin
        k_num_q[j]       <= NUM_W'(j_na_q[j]) + NUM_W'(j_dv_q >> 1);
        k_side_q[j].src  <= j_src_q[j];
        k_side_q[j].neg  <= j_neg_q[j];
        k_side_q[j].skip <= j_skip_q;
      end
    end
  end

  logic [NCH-1:0] q_v, q_ovf;
  logic [NCH-1:0][Q_W-1:0] q_quo;
  lane_side_t [NCH-1:0] q_side;

  for (genvar j = 0; j < NCH; j++) begin : g_lane
    lspp_div #(.PW(LSW)) u_div (
      .clk_i, .rst_ni, .en_i(en), .valid_i(k_v_q), .num_i(k_num_q[j]), .den_i(k_dv_q),
      .side_i(k_side_q[j]), .valid_o(q_v[j]), .quo_o(q_quo[j]), .ovf_o(q_ovf[j]),
      .side_o(q_side[j])
    );
  end

  // apply correction and saturate
  logic [NCH-1:0][PIX_W-1:0] out_d;

  always_comb begin
    logic [Q_W:0]  mag_c;
    logic [OW-1:0] o;
    for (int j = 0; j < NCH; j++) begin
      mag_c = q_ovf[j] ? ((Q_W + 1)'(1) << Q_W) : (Q_W + 1)'(q_quo[j]);
      o     = q_side[j].neg ? OW'(q_side[j].src) - OW'(mag_c)
                            : OW'(q_side[j].src) + OW'(mag_c);
      if (q_side[j].skip) out_d[j] = q_side[j].src;
      else if (o[OW-1]) out_d[j] = '0;
      else if (o[OW-2:PIX_W] != '0) out_d[j] = '1;
      else out_d[j] = o[PIX_W-1:0];
      if (cfg.single && j != 0) out_d[j] = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_valid_q <= 1'b0;
    else if (en) out_valid_q <= q_v[0];
  end

  always_ff @(posedge clk_i) begin
    if (en) out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_ch0_o   = out_q[0];
  assign out_ch1_o   = out_q[1];
  assign out_ch2_o   = out_q[2];

endmodule

>>> sv/lspp_checker.sv
module lspp_sva (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       in_valid_i,
  input logic                       in_ready_o,
  input logic                       out_valid_o,
  input logic                       out_ready_i,
  input logic [lspp_pkg::PIX_W-1:0] out_ch0_o,
  input logic [lspp_pkg::PIX_W-1:0] out_ch1_o,
  input logic [lspp_pkg::PIX_W-1:0] out_ch2_o
);

  // an empty output register never blocks the input side
  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input stalled with empty output");

  // a word taken at the output frees the input in the same cycle
  a_ready_on_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i |-> in_ready_o)
    else $error("input stalled while output drains");

  // a stalled output keeps its word and blocks new input
  a_stall_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |-> !in_ready_o)
    else $error("input taken during output stall");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_ch0_o)
      && $stable(out_ch1_o) && $stable(out_ch2_o))
    else $error("stalled output word changed");

endmodule

bind local_statistics_prior_pixel_core lspp_sva u_lspp_sva (.*);

>>> verif/lspp_checker.sv
`timescale 1ns / 1ps

module lspp_checker #(
  parameter int unsigned FUNC_TABLE_DEPTH = 1024
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  input  logic                         in_ready_i,
  input  logic [lspp_pkg::PIX_W-1:0]   src_ch0_i,
  input  logic [lspp_pkg::PIX_W-1:0]   src_ch1_i,
  input  logic [lspp_pkg::PIX_W-1:0]   src_ch2_i,
  input  logic [lspp_pkg::PIX_W-1:0]   smooth_ch0_i,
  input  logic [lspp_pkg::PIX_W-1:0]   smooth_ch1_i,
  input  logic [lspp_pkg::PIX_W-1:0]   smooth_ch2_i,
  input  logic                         out_valid_i,
  input  logic                         out_ready_i,
  input  logic [lspp_pkg::PIX_W-1:0]   out_ch0_i,
  input  logic [lspp_pkg::PIX_W-1:0]   out_ch1_i,
  input  logic [lspp_pkg::PIX_W-1:0]   out_ch2_i,
  input  logic                         psel_i,
  input  logic                         penable_i,
  input  logic                         pwrite_i,
  input  logic [lspp_pkg::PADDR_W-1:0] paddr_i,
  input  logic [lspp_pkg::PDATA_W-1:0] pwdata_i,
  input  logic                         pready_i,
  output int                           errors_o,
  output int                           pending_o
);
  import lspp_pkg::*;

  typedef struct packed {
    logic [PIX_W-1:0] ch0;
    logic [PIX_W-1:0] ch1;
    logic [PIX_W-1:0] ch2;
  } pixel_t;

  logic [PIX_W-1:0] exp_tab [FUNC_TABLE_DEPTH];
  logic [PIX_W-1:0] erf_tab [FUNC_TABLE_DEPTH];
  cfg_t             cfg;
  pixel_t           filtered_q [$];
  int               errors;

  assign errors_o  = errors;
  assign pending_o = filtered_q.size();

  function automatic longint unsigned mul_q32(longint unsigned a, longint unsigned b);
    return (a * b + 64'h8000_0000) >> 32;
  endfunction

  function automatic logic [PIX_W-1:0] q32_to_q16(longint unsigned x);
    longint unsigned v;
    v = (x + 64'd32768) >> 16;
    return (v > 64'd65535) ? 16'hffff : v[PIX_W-1:0];
  endfunction

  // exp(-x^2) by recurrence in q0.32, erf by trapezoid sum of it
  initial begin
    longint unsigned dd, y, t2, t3, r, r2, e, q, acc, e_new, integral;
    dd = longint'(FUNC_TABLE_DEPTH) * longint'(FUNC_TABLE_DEPTH);
    y  = ((64'd16 << 32) + dd / 2) / dd;
    t2 = ((y * y) >> 32) / 2;
    t3 = ((t2 * y) >> 32) / 3;
    r  = (64'd1 << 32) - y + t2 - t3;
    r2 = mul_q32(r, r);
    e  = 64'd1 << 32;
    q  = r;
    acc = 0;
    exp_tab[0] = q32_to_q16(e);
    erf_tab[0] = '0;
    for (int k = 1; k < FUNC_TABLE_DEPTH; k++) begin
      e_new = mul_q32(e, q);
      acc += e + e_new;
      integral = (acc * 2 + FUNC_TABLE_DEPTH / 2) / FUNC_TABLE_DEPTH;
      exp_tab[k] = q32_to_q16(e_new);
      erf_tab[k] = q32_to_q16((integral * 64'd2423175810 + 64'h4000_0000) >> 31);
      e = e_new;
      q = mul_q32(q, r2);
    end
  end

  function automatic longint unsigned sqrt_floor(longint unsigned v);
    longint unsigned res, bitv;
    res  = 0;
    bitv = 64'd1 << 40;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  function automatic pixel_t filter_pixel(logic [3*PIX_W-1:0] src, logic [3*PIX_W-1:0] smooth);
    longint          s [3];
    longint          d [3];
    longint unsigned sq, mag, prod, idx, ex, er, den, dv, na, c;
    longint          num, n, o;
    int              nch;
    logic [PIX_W-1:0] res [3];
    nch = cfg.single ? 1 : 3;
    sq  = 0;
    for (int j = 0; j < 3; j++) begin
      s[j] = longint'(src[j*PIX_W +: PIX_W]);
      d[j] = s[j] - longint'(smooth[j*PIX_W +: PIX_W]);
      res[j] = '0;
    end
    for (int j = 0; j < nch; j++) sq += (d[j] < 0 ? -d[j] : d[j]) * (d[j] < 0 ? -d[j] : d[j]);
    mag  = sqrt_floor(sq);
    prod = (longint'(cfg.delta_offset) + 2 * mag) * longint'(cfg.inv_scale);
    idx  = (prod * FUNC_TABLE_DEPTH + 64'h8000_0000) >> 32;
    if (idx < FUNC_TABLE_DEPTH) begin
      ex = exp_tab[idx];
      er = erf_tab[idx];
    end else begin
      ex = 0;
      er = 65535;
    end
    num = longint'(ex) - longint'(cfg.exp_delta);
    den = er + longint'(cfg.erf_delta);
    for (int j = 0; j < nch; j++) begin
      o = s[j];
      if (mag != 0 && den != 0) begin
        n  = num * longint'(cfg.gain) * d[j];
        dv = den * mag;
        na = (n < 0) ? -n : n;
        c  = (na + dv / 2) / dv;
        o  = (n < 0) ? o - longint'(c) : o + longint'(c);
      end
      if (o < 0) o = 0;
      if (o > 65535) o = 65535;
      res[j] = o[PIX_W-1:0];
    end
    return '{ch0: res[0], ch1: res[1], ch2: res[2]};
  endfunction

  task automatic report_mismatch(string what, logic [PIX_W-1:0] got, logic [PIX_W-1:0] want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    errors++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    pixel_t want;
    if (!rst_ni) begin
      cfg <= '{single: 1'b0, delta_offset: '0, inv_scale: INV_SCALE_RST, gain: GAIN_RST,
               exp_delta: EXP_DELTA_RST, erf_delta: '0};
      filtered_q.delete();
      errors = 0;
    end else begin
      if (psel_i && penable_i && pwrite_i && pready_i) begin
        case (reg_idx_e'(paddr_i[PADDR_W-1:2]))
          REG_SINGLE:    cfg.single       <= pwdata_i[0];
          REG_DELTA:     cfg.delta_offset <= pwdata_i[PIX_W-1:0];
          REG_INV_SCALE: cfg.inv_scale    <= pwdata_i[ISCL_W-1:0];
          REG_GAIN:      cfg.gain         <= pwdata_i[PIX_W-1:0];
          REG_EXP_DELTA: cfg.exp_delta    <= pwdata_i[PIX_W-1:0];
          REG_ERF_DELTA: cfg.erf_delta    <= pwdata_i[PIX_W-1:0];
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i)
        filtered_q.push_back(filter_pixel({src_ch2_i, src_ch1_i, src_ch0_i},
                                          {smooth_ch2_i, smooth_ch1_i, smooth_ch0_i}));
      if (out_valid_i && out_ready_i) begin
        if (filtered_q.size() == 0) begin
          $display("unexpected output word at %0t", $realtime);
          errors++;
        end else begin
          want = filtered_q.pop_front();
          if (out_ch0_i !== want.ch0) report_mismatch("out_ch0", out_ch0_i, want.ch0);
          if (out_ch1_i !== want.ch1) report_mismatch("out_ch1", out_ch1_i, want.ch1);
          if (out_ch2_i !== want.ch2) report_mismatch("out_ch2", out_ch2_i, want.ch2);
        end
      end
    end
  end

endmodule

>>> verif/tb_local_statistics_prior_pixel_core.sv
`timescale 1ns / 1ps

module tb_local_statistics_prior_pixel_core;
  import lspp_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned DRAIN_CYCLES = 80;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [PIX_W-1:0]   src [3] = '{default: '0};
  logic [PIX_W-1:0]   smooth [3] = '{default: '0};
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [PIX_W-1:0]   out_ch0, out_ch1, out_ch2;
  logic               psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [PDATA_W-1:0] pwdata = '0;
  logic [PDATA_W-1:0] prdata;
  logic               pready;
  int                 errors, pending;
  int                 cycles = 0;
  bit                 quiet = 1'b0;

  always #10 clk_i = ~clk_i;

  local_statistics_prior_pixel_core i_dut (
    .clk_i, .rst_ni,
    .in_valid_i(in_valid), .in_ready_o(in_ready),
    .src_ch0_i(src[0]), .src_ch1_i(src[1]), .src_ch2_i(src[2]),
    .smooth_ch0_i(smooth[0]), .smooth_ch1_i(smooth[1]), .smooth_ch2_i(smooth[2]),
    .out_valid_o(out_valid), .out_ready_i(out_ready),
    .out_ch0_o(out_ch0), .out_ch1_o(out_ch1), .out_ch2_o(out_ch2),
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  lspp_checker i_checker (
    .clk_i, .rst_ni,
    .in_valid_i(in_valid), .in_ready_i(in_ready),
    .src_ch0_i(src[0]), .src_ch1_i(src[1]), .src_ch2_i(src[2]),
    .smooth_ch0_i(smooth[0]), .smooth_ch1_i(smooth[1]), .smooth_ch2_i(smooth[2]),
    .out_valid_i(out_valid), .out_ready_i(out_ready),
    .out_ch0_i(out_ch0), .out_ch1_i(out_ch1), .out_ch2_i(out_ch2),
    .psel_i(psel), .penable_i(penable), .pwrite_i(pwrite), .paddr_i(paddr),
    .pwdata_i(pwdata), .pready_i(pready),
    .errors_o(errors), .pending_o(pending)
  );

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL local_statistics_prior_pixel_core");
      $finish;
    end
  end

  // output side stalls in bursts
  initial begin
    @(posedge clk_i);
    while (!rst_ni) @(posedge clk_i);
    forever begin
      if (!quiet && $urandom_range(0, 2) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk_i);
      end
      out_ready <= 1'b1;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
    end
  end

  task automatic write_reg(reg_idx_e idx, logic [PDATA_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic load_config(logic single, logic [15:0] delta, logic [23:0] iscale,
                             logic [15:0] g, logic [15:0] ed, logic [15:0] fd);
    write_reg(REG_SINGLE, PDATA_W'(single));
    write_reg(REG_DELTA, PDATA_W'(delta));
    write_reg(REG_INV_SCALE, PDATA_W'(iscale));
    write_reg(REG_GAIN, PDATA_W'(g));
    write_reg(REG_EXP_DELTA, PDATA_W'(ed));
    write_reg(REG_ERF_DELTA, PDATA_W'(fd));
  endtask

  // present one word and hold it until the pipe takes it
  task automatic send_pixel(logic [15:0] s0, s1, s2, m0, m1, m2);
    in_valid  <= 1'b1;
    src[0]    <= s0;
    src[1]    <= s1;
    src[2]    <= s2;
    smooth[0] <= m0;
    smooth[1] <= m1;
    smooth[2] <= m2;
    forever begin
      @(negedge clk_i);
      if (in_ready) break;
    end
    @(posedge clk_i);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
  endtask

  function automatic logic [15:0] pick_level();
    case ($urandom_range(0, 3))
      0:       return 16'h0000;
      1:       return 16'hffff;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic send_random_pixel();
    logic [15:0] s [3];
    logic [15:0] m [3];
    int          kind;
    kind = $urandom_range(0, 3);
    for (int j = 0; j < 3; j++) begin
      s[j] = 16'($urandom);
      case (kind)
        0: m[j] = 16'($urandom);
        1: m[j] = s[j] + 16'($urandom_range(0, 600)) - 16'd300;
        2: m[j] = s[j];
        default: begin
          s[j] = pick_level();
          m[j] = pick_level();
        end
      endcase
    end
    send_pixel(s[0], s[1], s[2], m[0], m[1], m[2]);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // reset settings: zero magnitude, one lsb, extremes, zero denominator at idx 0
    send_pixel(0, 0, 0, 0, 0, 0);
    send_pixel(16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff);
    send_pixel(16'hffff, 16'hffff, 16'hffff, 0, 0, 0);
    send_pixel(0, 0, 0, 16'hffff, 16'hffff, 16'hffff);
    send_pixel(16'h1234, 16'h0800, 16'h0400, 16'h1233, 16'h0800, 16'h0400);
    send_pixel(16'h8000, 16'h4000, 16'h2000, 16'h7f00, 16'h4100, 16'h2000);
    send_pixel(16'hffff, 0, 16'h8000, 0, 16'hffff, 16'h8000);
    send_pixel(16'h0100, 16'h0200, 16'h0300, 16'h0000, 16'h0400, 16'h0100);
    repeat (100) send_random_pixel();
    drain();

    // gray mode, full gain, past-table lookups likely
    load_config(1'b1, 16'h0200, 24'd200000, 16'hffff, 16'h0000, 16'hffff);
    send_pixel(16'h0100, 16'hffff, 16'hffff, 16'h00ff, 0, 0);
    send_pixel(16'hffff, 1, 2, 0, 3, 4);
    repeat (100) send_random_pixel();
    drain();

    // widest prior and scale, zero gain
    load_config(1'b0, 16'hffff, 24'hffffff, 16'h0000, 16'hffff, 16'hffff);
    repeat (80) send_random_pixel();
    drain();

    // zero scale pins the lookup at entry 0, so the denominator is zero
    load_config(1'b0, 16'h0000, 24'h000000, 16'd12000, 16'd30000, 16'h0000);
    repeat (80) send_random_pixel();
    drain();

    for (int p = 0; p < 2; p++) begin
      load_config(1'($urandom_range(0, 1)), 16'($urandom), 24'($urandom_range(0, 400000)),
                  16'($urandom), 16'($urandom), 16'($urandom));
      repeat (60) send_random_pixel();
      drain();
    end

    // back to reset values, then a stretch with no idling
    load_config(1'b0, 16'h0000, INV_SCALE_RST, GAIN_RST, EXP_DELTA_RST, 16'h0000);
    quiet = 1'b1;
    repeat (120) send_random_pixel();
    drain();

    if (errors == 0)
      $display("PASS local_statistics_prior_pixel_core");
    else
      $display("FAIL local_statistics_prior_pixel_core");
    $finish;
  end

endmodule
